>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/tpru_pkg.sv
package tpru_pkg;

	localparam int MAX_SIDE  = 64;
	localparam int MAX_SCALE = 8;

	localparam int SCALE_W = $clog2(MAX_SCALE + 1);
	localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
	localparam int COORD_W = $clog2(MAX_SIDE);
	localparam int BIGW_W  = $clog2(MAX_SIDE * MAX_SCALE + 1);
	localparam int POS_W   = $clog2(MAX_SIDE * MAX_SCALE);
	localparam int IDX_W   = 18;
	localparam int CHAN_W  = 8;
	localparam int WGT_W   = 9;
	localparam int CFG_W   = 9;
	localparam int CFG_IDX_W = 3;

	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TINT_RED,
		REG_TINT_GREEN,
		REG_TINT_BLUE,
		REG_BLEND_WEIGHT,
		REG_ALPHA_THRESHOLD,
		REG_MONO_MODE,
		REG_SCALE_FACTOR,
		REG_SOURCE_WIDTH
	} cfg_reg_t;

	typedef struct packed {
		logic [CHAN_W-1:0]  tint_red;
		logic [CHAN_W-1:0]  tint_green;
		logic [CHAN_W-1:0]  tint_blue;
		logic [WGT_W-1:0]   blend_weight;
		logic [WGT_W-1:0]   alpha_threshold;
		logic               mono_mode;
		logic [3:0]         scale_factor;
		logic [6:0]         source_width;
	} cfg_t;

	typedef struct packed {
		logic [5:0]        pix_x;
		logic [5:0]        pix_y;
		logic [CHAN_W-1:0] in_red;
		logic [CHAN_W-1:0] in_green;
		logic [CHAN_W-1:0] in_blue;
		logic [CHAN_W-1:0] in_alpha;
	} src_t;

	typedef struct packed {
		logic [IDX_W-1:0]  dest_index;
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_alpha;
		logic              last_copy;
	} dst_t;

	// One classified pixel handed from front end to back end.
	typedef struct packed {
		logic [IDX_W-1:0]   base;
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic [SCALE_W-1:0] scale;
		logic [BIGW_W-1:0]  big_w;
	} job_t;

endpackage

>>> hw/rtl/tint_and_pixel_replicate_upscale.sv
// Tint and pixel-replicate upscaler.
// Input: raise start with a source pixel on src; the word is taken at a rising
// edge where start is high and busy is low. Output: each copy appears on dst
// for one cycle with dst_strobe high; the receiver cannot stall, so there is
// no backpressure on the result side.
// Configuration: write cfg_data to register cfg_index with cfg_we, only while
// no pixel is in flight.
// Each pixel yields scale*scale copies, one per cycle, column of the block
// outer and row inner; last_copy marks the final one.
// Path: with the back end free, the first copy reaches dst through the two
// front stages, the queue, the back end active register and the output
// register. Throughput: the back end emits one copy per cycle while it holds
// a pixel; a four-entry queue lets the front end keep taking pixels while
// the back end replicates.
// Reset: registers return to their defaults (tint black, weight 0, threshold
// 1, colour mode, scale 1, width 32), queue empties, no strobe.
module tint_and_pixel_replicate_upscale import tpru_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  src_t                 src,
	output logic                 dst_strobe,
	output dst_t                 dst,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t               cfg_q;
	logic               accept;
	logic               push;
	logic               pop;
	logic               empty;
	logic [1:0]         in_flight;
	logic [Q_CNT_W-1:0] count;
	job_t               wr_job;
	job_t               rd_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tint_red        <= '0;
			cfg_q.tint_green      <= '0;
			cfg_q.tint_blue       <= '0;
			cfg_q.blend_weight    <= '0;
			cfg_q.alpha_threshold <= WGT_W'(1);
			cfg_q.mono_mode       <= 1'b0;
			cfg_q.scale_factor    <= 4'd1;
			cfg_q.source_width    <= 7'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TINT_RED:        cfg_q.tint_red        <= cfg_data[CHAN_W-1:0];
				REG_TINT_GREEN:      cfg_q.tint_green      <= cfg_data[CHAN_W-1:0];
				REG_TINT_BLUE:       cfg_q.tint_blue       <= cfg_data[CHAN_W-1:0];
				REG_BLEND_WEIGHT:    cfg_q.blend_weight    <= cfg_data[WGT_W-1:0];
				REG_ALPHA_THRESHOLD: cfg_q.alpha_threshold <= cfg_data[WGT_W-1:0];
				REG_MONO_MODE:       cfg_q.mono_mode       <= cfg_data[0];
				REG_SCALE_FACTOR:    cfg_q.scale_factor    <= cfg_data[3:0];
				REG_SOURCE_WIDTH:    cfg_q.source_width    <= cfg_data[6:0];
			endcase
		end
	end

	// hold off new words once queue plus front stages could fill the queue
	assign busy   = (Q_CNT_W'(count) + Q_CNT_W'(in_flight)) >= Q_CNT_W'(Q_DEPTH);
	assign accept = start && !busy;

	tpru_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.src       (src),
		.push      (push),
		.job       (wr_job),
		.in_flight (in_flight)
	);

	tpru_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (empty),
		.count  (count)
	);

	tpru_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.job    (rd_job),
		.pop    (pop),
		.strobe (dst_strobe),
		.word   (dst)
	);

endmodule

>>> hw/rtl/tpru_front.sv
module tpru_front import tpru_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic accept,
	input  src_t src,
	output logic push,
	output job_t job,
	output logic [1:0] in_flight
);

	logic               valid_s1;
	logic               valid_s2;
	logic               opaque_s1;
	logic [CHAN_W-1:0]  red_s1, green_s1, blue_s1;
	logic signed [18:0] prod_r_s1, prod_g_s1, prod_b_s1;
	logic [POS_W-1:0]   row0_s1, col0_s1;
	logic [BIGW_W-1:0]  big_w_s1;
	logic [SCALE_W-1:0] scale_s1;
	job_t               job_s2;

	logic [SCALE_W-1:0] s_c;
	logic [SIDE_W-1:0]  sw_c;
	logic [WGT_W-1:0]   w_c;
	logic               opaque_c;
	logic [BIGW_W+POS_W-1:0] row_prod;
	logic signed [18:0] sum_r, sum_g, sum_b;

	function automatic logic signed [18:0] blend_prod(input logic [CHAN_W-1:0] tint,
			input logic [CHAN_W-1:0] pix, input logic [WGT_W-1:0] w);
		logic signed [18:0] diff;
		logic signed [18:0] wt;
		diff = $signed({11'b0, tint}) - $signed({11'b0, pix});
		wt   = $signed({10'b0, w});
		return diff * wt;
	endfunction

	always_comb begin
		if (cfg.scale_factor == '0) begin
			s_c = SCALE_W'(1);
		end else if (cfg.scale_factor > SCALE_W'(MAX_SCALE)) begin
			s_c = SCALE_W'(MAX_SCALE);
		end else begin
			s_c = cfg.scale_factor;
		end
		if (cfg.source_width == '0) begin
			sw_c = SIDE_W'(1);
		end else if (cfg.source_width > SIDE_W'(MAX_SIDE)) begin
			sw_c = SIDE_W'(MAX_SIDE);
		end else begin
			sw_c = cfg.source_width;
		end
		w_c = (cfg.blend_weight > WGT_W'(256)) ? WGT_W'(256) : cfg.blend_weight;
		if (cfg.mono_mode) begin
			opaque_c = (src.in_red != '0) && (src.in_green != '0) && (src.in_blue != '0);
		end else begin
			opaque_c = {1'b0, src.in_alpha} >= cfg.alpha_threshold;
		end
	end

	// stage 1: classify, blend products, block origin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opaque_s1 <= opaque_c;
			red_s1    <= src.in_red;
			green_s1  <= src.in_green;
			blue_s1   <= src.in_blue;
			prod_r_s1 <= blend_prod(cfg.tint_red, src.in_red, w_c);
			prod_g_s1 <= blend_prod(cfg.tint_green, src.in_green, w_c);
			prod_b_s1 <= blend_prod(cfg.tint_blue, src.in_blue, w_c);
			row0_s1   <= POS_W'(src.pix_y * s_c);
			col0_s1   <= POS_W'(src.pix_x * s_c);
			big_w_s1  <= BIGW_W'(sw_c * s_c);
			scale_s1  <= s_c;
		end
	end

	// src + floor((tint - src) * w / 256) equals the truncated blend
	always_comb begin
		sum_r    = $signed({11'b0, red_s1}) + (prod_r_s1 >>> 8);
		sum_g    = $signed({11'b0, green_s1}) + (prod_g_s1 >>> 8);
		sum_b    = $signed({11'b0, blue_s1}) + (prod_b_s1 >>> 8);
		row_prod = row0_s1 * big_w_s1;
	end

	// stage 2: final colour and base index of the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			job_s2.red   <= opaque_s1 ? sum_r[CHAN_W-1:0] : '0;
			job_s2.green <= opaque_s1 ? sum_g[CHAN_W-1:0] : '0;
			job_s2.blue  <= opaque_s1 ? sum_b[CHAN_W-1:0] : '0;
			job_s2.base  <= IDX_W'(row_prod) + IDX_W'(col0_s1);
			job_s2.scale <= scale_s1;
			job_s2.big_w <= big_w_s1;
		end
	end

	assign push      = valid_s2;
	assign job       = job_s2;
	assign in_flight = {1'b0, valid_s1} + {1'b0, valid_s2};

endmodule

>>> hw/rtl/tpru_fifo.sv
module tpru_fifo import tpru_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  job_t               wr_job,
	input  logic               pop,
	output job_t               rd_job,
	output logic               empty,
	output logic [Q_CNT_W-1:0] count
);

	job_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	assign rd_job = mem_q[rd_ptr_q];
	assign empty  = (count_q == '0);
	assign count  = count_q;

endmodule

>>> hw/rtl/tpru_back.sv
module tpru_back import tpru_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  job_t job,
	output logic pop,
	output logic strobe,
	output dst_t word
);

	logic               active_q;
	logic [SCALE_W-1:0] bx_q, by_q;
	logic [IDX_W-1:0]   idx_q;
	job_t               cur_q;
	logic               strobe_q;
	dst_t               word_q;
	logic               col_end;
	logic               last_now;

	assign col_end  = (by_q == cur_q.scale - SCALE_W'(1));
	assign last_now = col_end && (bx_q == cur_q.scale - SCALE_W'(1));
	assign pop      = !empty && (!active_q || last_now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			bx_q     <= '0;
			by_q     <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				bx_q     <= '0;
				by_q     <= '0;
			end else if (active_q && last_now) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				// by runs inside bx
				if (col_end) begin
					by_q <= '0;
					bx_q <= bx_q + SCALE_W'(1);
				end else begin
					by_q <= by_q + SCALE_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= job;
			idx_q <= job.base;
		end else if (active_q) begin
			if (col_end) begin
				idx_q <= cur_q.base + IDX_W'(bx_q) + IDX_W'(1);
			end else begin
				idx_q <= idx_q + IDX_W'(cur_q.big_w);
			end
		end
		if (active_q) begin
			word_q.dest_index <= idx_q;
			word_q.out_red    <= cur_q.red;
			word_q.out_green  <= cur_q.green;
			word_q.out_blue   <= cur_q.blue;
			word_q.out_alpha  <= ALPHA_OPAQUE;
			word_q.last_copy  <= last_now;
		end
	end

	assign strobe = strobe_q;
	assign word   = word_q;

endmodule

>>> hw/rtl/tpru_checker.sv
`include "assert_macros.svh"

module tpru_checker import tpru_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic dst_strobe,
	input dst_t dst
);

	logic [3*CHAN_W-1:0] rgb;

	assign rgb = {dst.out_red, dst.out_green, dst.out_blue};

	// copies of one pixel leave back to back
	`CHK_NEXT(a_copies_contiguous, clk, arst_n, dst_strobe && !dst.last_copy, dst_strobe)

	// all copies of one pixel carry the same colour
	`CHK_NEXT(a_colour_steady, clk, arst_n, dst_strobe && !dst.last_copy, rgb == $past(rgb))

	`CHK_SAME(a_alpha_full, clk, arst_n, dst_strobe, dst.out_alpha == ALPHA_OPAQUE)

	`CHK_SAME(a_busy_known, clk, arst_n, start, !$isunknown(busy))

endmodule

bind tint_and_pixel_replicate_upscale tpru_checker u_tpru_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.dst_strobe (dst_strobe),
	.dst        (dst)
);
